### design/pdmd_pkg.sv
// Shared types, widths and register map for the PID differential motor drive.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package pdmd_pkg;

  // Basic field widths
  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int GAIN_BITS   = 25;
  localparam int DRIVE_BITS  = 20;
  localparam int LIMIT_BITS  = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;

  // Derived datapath widths
  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int DER_W  = SAMPLE_BITS + 2;
  localparam int SUM_W  = ((LIMIT_BITS > SAMPLE_BITS) ? LIMIT_BITS : SAMPLE_BITS) + 2;
  localparam int PP_W   = GAIN_BITS + ERR_W;
  localparam int PI_W   = GAIN_BITS + SUM_W;
  localparam int PD_W   = GAIN_BITS + DER_W;
  localparam int ACC_W  = PI_W + 2;
  localparam int CORR_W = ACC_W - FRAC_BITS;
  localparam int DRV_W  = CORR_W + 2;

  typedef logic [SAMPLE_BITS-1:0]       sample_t;
  typedef logic signed [GAIN_BITS-1:0]  gain_t;
  typedef logic [DRIVE_BITS-1:0]        pulse_t;
  typedef logic [LIMIT_BITS-1:0]        limit_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic signed [DER_W-1:0]      der_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [PP_W-1:0]       pp_t;
  typedef logic signed [PI_W-1:0]       pi_t;
  typedef logic signed [PD_W-1:0]       pd_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [CORR_W-1:0]     corr_t;
  typedef logic signed [DRV_W-1:0]      drv_t;
  typedef logic [DRV_W-1:0]             mag_t;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_DERIV_GAIN = 3'd3,
    REG_BASE_SPEED = 3'd4,
    REG_INTEG_LIM  = 3'd5,
    REG_PULSE_LIM  = 3'd6
  } reg_idx_t;

  // Reset values
  localparam sample_t RST_SETPOINT   = sample_t'(162);
  localparam gain_t   RST_PROP_GAIN  = gain_t'(2048000);
  localparam gain_t   RST_INTEG_GAIN = gain_t'(0);
  localparam gain_t   RST_DERIV_GAIN = gain_t'(5120);
  localparam pulse_t  RST_BASE_SPEED = pulse_t'(800000);
  localparam limit_t  RST_INTEG_LIM  = limit_t'(3000);
  localparam pulse_t  RST_PULSE_LIM  = pulse_t'(1000000);

  typedef struct packed {
    sample_t setpoint;
    gain_t   prop_gain;
    gain_t   integ_gain;
    gain_t   deriv_gain;
    pulse_t  base_speed;
    limit_t  integ_lim;
    pulse_t  pulse_lim;
  } cfg_t;

  typedef struct packed {
    logic   fwd;
    pulse_t pulse;
  } drive_out_t;

endpackage

`default_nettype wire

### design/pdmd_regs.sv
// APB-style configuration register file for the motor drive.
// Depends on pdmd_pkg for the register map, reset values and cfg_t.
`default_nettype none

module pdmd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdmd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pdmd_pkg::DATA_W-1:0] pwdata,
  output logic      [pdmd_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output pdmd_pkg::cfg_t                   cfg
);

  pdmd_pkg::cfg_t     cfg_r;
  pdmd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = pdmd_pkg::reg_idx_t'(paddr[pdmd_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= pdmd_pkg::RST_SETPOINT;
      cfg_r.prop_gain  <= pdmd_pkg::RST_PROP_GAIN;
      cfg_r.integ_gain <= pdmd_pkg::RST_INTEG_GAIN;
      cfg_r.deriv_gain <= pdmd_pkg::RST_DERIV_GAIN;
      cfg_r.base_speed <= pdmd_pkg::RST_BASE_SPEED;
      cfg_r.integ_lim  <= pdmd_pkg::RST_INTEG_LIM;
      cfg_r.pulse_lim  <= pdmd_pkg::RST_PULSE_LIM;
    end else if (wr_en) begin
      case (idx)
        pdmd_pkg::REG_SETPOINT:   cfg_r.setpoint   <= pwdata[pdmd_pkg::SAMPLE_BITS-1:0];
        pdmd_pkg::REG_PROP_GAIN:  cfg_r.prop_gain  <= pwdata[pdmd_pkg::GAIN_BITS-1:0];
        pdmd_pkg::REG_INTEG_GAIN: cfg_r.integ_gain <= pwdata[pdmd_pkg::GAIN_BITS-1:0];
        pdmd_pkg::REG_DERIV_GAIN: cfg_r.deriv_gain <= pwdata[pdmd_pkg::GAIN_BITS-1:0];
        pdmd_pkg::REG_BASE_SPEED: cfg_r.base_speed <= pwdata[pdmd_pkg::DRIVE_BITS-1:0];
        pdmd_pkg::REG_INTEG_LIM:  cfg_r.integ_lim  <= pwdata[pdmd_pkg::LIMIT_BITS-1:0];
        pdmd_pkg::REG_PULSE_LIM:  cfg_r.pulse_lim  <= pwdata[pdmd_pkg::DRIVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Gains read back sign-extended, the rest zero-extended.
  always_comb begin
    case (idx)
      pdmd_pkg::REG_SETPOINT:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::SAMPLE_BITS){1'b0}}, cfg_r.setpoint};
      pdmd_pkg::REG_PROP_GAIN:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::GAIN_BITS){cfg_r.prop_gain[pdmd_pkg::GAIN_BITS-1]}},
                  cfg_r.prop_gain};
      pdmd_pkg::REG_INTEG_GAIN:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::GAIN_BITS){cfg_r.integ_gain[pdmd_pkg::GAIN_BITS-1]}},
                  cfg_r.integ_gain};
      pdmd_pkg::REG_DERIV_GAIN:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::GAIN_BITS){cfg_r.deriv_gain[pdmd_pkg::GAIN_BITS-1]}},
                  cfg_r.deriv_gain};
      pdmd_pkg::REG_BASE_SPEED:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::DRIVE_BITS){1'b0}}, cfg_r.base_speed};
      pdmd_pkg::REG_INTEG_LIM:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::LIMIT_BITS){1'b0}}, cfg_r.integ_lim};
      pdmd_pkg::REG_PULSE_LIM:
        prdata = {{(pdmd_pkg::DATA_W-pdmd_pkg::DRIVE_BITS){1'b0}}, cfg_r.pulse_lim};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/pdmd_err.sv
// Error stage: forms error, clamped error sum and derivative, and holds the PID state.
// Depends on pdmd_pkg for widths and cfg_t.
`default_nettype none

module pdmd_err (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  pdmd_pkg::cfg_t              cfg,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  pdmd_pkg::sample_t           position,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output pdmd_pkg::err_t              err,
  output pdmd_pkg::sum_t              sum,
  output pdmd_pkg::der_t              der
);

  logic             valid_r;
  pdmd_pkg::err_t   last_error_r;
  pdmd_pkg::sum_t   error_sum_r;
  pdmd_pkg::der_t   der_r;
  pdmd_pkg::err_t   err_nxt;
  pdmd_pkg::sum_t   sum_raw;
  pdmd_pkg::sum_t   lim;
  pdmd_pkg::sum_t   error_sum_nxt;
  pdmd_pkg::der_t   der_nxt;
  logic             take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  assign err_nxt = pdmd_pkg::err_t'(cfg.setpoint) - pdmd_pkg::err_t'(position);
  assign sum_raw = error_sum_r + pdmd_pkg::sum_t'(err_nxt);
  assign lim     = pdmd_pkg::sum_t'(cfg.integ_lim);
  assign der_nxt = pdmd_pkg::der_t'(err_nxt) - pdmd_pkg::der_t'(last_error_r);

  always_comb begin
    if (sum_raw > lim) begin
      error_sum_nxt = lim;
    end else if (sum_raw < -lim) begin
      error_sum_nxt = -lim;
    end else begin
      error_sum_nxt = sum_raw;
    end
  end

  // The state registers double as this stage's output: they only move on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (take) begin
        last_error_r <= err_nxt;
        error_sum_r  <= error_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      der_r <= der_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign err      = last_error_r;
  assign sum      = error_sum_r;
  assign der      = der_r;

endmodule

`default_nettype wire

### design/pdmd_mul.sv
// Product stage: three signed gain multiplies, each registered.
// Depends on pdmd_pkg for widths and cfg_t.
`default_nettype none

module pdmd_mul (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  pdmd_pkg::cfg_t  cfg,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  pdmd_pkg::err_t  err,
  input  pdmd_pkg::sum_t  sum,
  input  pdmd_pkg::der_t  der,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output pdmd_pkg::pp_t   prod_p,
  output pdmd_pkg::pi_t   prod_i,
  output pdmd_pkg::pd_t   prod_d
);

  logic           valid_r;
  pdmd_pkg::pp_t  prod_p_r;
  pdmd_pkg::pi_t  prod_i_r;
  pdmd_pkg::pd_t  prod_d_r;

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Sign-extend both operands to the full product width.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_p_r <= pdmd_pkg::pp_t'(cfg.prop_gain) * pdmd_pkg::pp_t'(err);
      prod_i_r <= pdmd_pkg::pi_t'(cfg.integ_gain) * pdmd_pkg::pi_t'(sum);
      prod_d_r <= pdmd_pkg::pd_t'(cfg.deriv_gain) * pdmd_pkg::pd_t'(der);
    end
  end

  assign dn_valid = valid_r;
  assign prod_p   = prod_p_r;
  assign prod_i   = prod_i_r;
  assign prod_d   = prod_d_r;

endmodule

`default_nettype wire

### design/pdmd_drv.sv
// Drive stages: sum products into the correction, then form and saturate both drives.
// Depends on pdmd_pkg for widths, cfg_t and drive_out_t.
`default_nettype none

module pdmd_drv (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  pdmd_pkg::cfg_t     cfg,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  pdmd_pkg::pp_t      prod_p,
  input  pdmd_pkg::pi_t      prod_i,
  input  pdmd_pkg::pd_t      prod_d,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output pdmd_pkg::drive_out_t left,
  output pdmd_pkg::drive_out_t right
);

  logic                  corr_valid_r;
  pdmd_pkg::corr_t       corr_r;
  pdmd_pkg::acc_t        acc;
  logic                  corr_ready;
  logic                  out_valid_r;
  pdmd_pkg::drive_out_t  left_r;
  pdmd_pkg::drive_out_t  right_r;
  pdmd_pkg::drv_t        left_drv;
  pdmd_pkg::drv_t        right_drv;

  function automatic pdmd_pkg::drive_out_t shape(input pdmd_pkg::drv_t d,
                                                 input pdmd_pkg::pulse_t lim);
    pdmd_pkg::mag_t       mag;
    pdmd_pkg::mag_t       lim_w;
    pdmd_pkg::drive_out_t o;
    mag   = d[pdmd_pkg::DRV_W-1] ? pdmd_pkg::mag_t'(-d) : pdmd_pkg::mag_t'(d);
    lim_w = pdmd_pkg::mag_t'(lim);
    o.fwd = ~d[pdmd_pkg::DRV_W-1];
    o.pulse = (mag > lim_w) ? lim : mag[pdmd_pkg::DRIVE_BITS-1:0];
    return o;
  endfunction

  assign corr_ready = !out_valid_r || dn_ready;
  assign up_ready   = !corr_valid_r || corr_ready;

  // Floor shift: drop the fraction bits of the signed sum.
  assign acc = pdmd_pkg::acc_t'(prod_p) + pdmd_pkg::acc_t'(prod_i) + pdmd_pkg::acc_t'(prod_d);

  assign left_drv  = pdmd_pkg::drv_t'(cfg.base_speed) - pdmd_pkg::drv_t'(corr_r);
  assign right_drv = pdmd_pkg::drv_t'(cfg.base_speed) + pdmd_pkg::drv_t'(corr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (up_ready) begin
        corr_valid_r <= up_valid;
      end
      if (corr_ready) begin
        out_valid_r <= corr_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      corr_r <= acc[pdmd_pkg::ACC_W-1:pdmd_pkg::FRAC_BITS];
    end
    if (corr_ready && corr_valid_r) begin
      left_r  <= shape(left_drv, cfg.pulse_lim);
      right_r <= shape(right_drv, cfg.pulse_lim);
    end
  end

  assign dn_valid = out_valid_r;
  assign left     = left_r;
  assign right    = right_r;

endmodule

`default_nettype wire

### design/pid_differential_motor_drive.sv
// PID differential motor drive, top level.
// Throughput: one transaction per cycle; four register stages (error, products,
//   correction, drive) each hold one transaction and stall only when full and blocked.
// Reset (rst_n, synchronous, active low): all stages empty, error state zero,
//   configuration registers at their documented defaults.
`default_nettype none

module pid_differential_motor_drive (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input sample channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pdmd_pkg::SAMPLE_BITS-1:0] in_position,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_left_forward,
  output logic [pdmd_pkg::DRIVE_BITS-1:0]  out_left_pulse,
  output logic                             out_right_forward,
  output logic [pdmd_pkg::DRIVE_BITS-1:0]  out_right_pulse,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdmd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pdmd_pkg::DATA_W-1:0] pwdata,
  output logic      [pdmd_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  pdmd_pkg::cfg_t       cfg;

  // Error stage -> product stage
  logic                 e_valid;
  logic                 e_ready;
  pdmd_pkg::err_t       e_err;
  pdmd_pkg::sum_t       e_sum;
  pdmd_pkg::der_t       e_der;

  // Product stage -> drive stages
  logic                 m_valid;
  logic                 m_ready;
  pdmd_pkg::pp_t        m_prod_p;
  pdmd_pkg::pi_t        m_prod_i;
  pdmd_pkg::pd_t        m_prod_d;

  pdmd_pkg::drive_out_t left;
  pdmd_pkg::drive_out_t right;

  // Configuration registers; write only while the pipeline is drained (not enforced here).
  pdmd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1: error, clamped integral and derivative. The integral feedback
  // closes within this stage, so back-to-back samples see the fresh state.
  pdmd_err u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .position (in_position),
    .dn_valid (e_valid),
    .dn_ready (e_ready),
    .err      (e_err),
    .sum      (e_sum),
    .der      (e_der)
  );

  // Stage 2: three independent gain multiplies, registered.
  pdmd_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (e_valid),
    .up_ready (e_ready),
    .err      (e_err),
    .sum      (e_sum),
    .der      (e_der),
    .dn_valid (m_valid),
    .dn_ready (m_ready),
    .prod_p   (m_prod_p),
    .prod_i   (m_prod_i),
    .prod_d   (m_prod_d)
  );

  // Stages 3 and 4: add and shift into the correction, then split into
  // left/right drives with direction and saturated magnitude. The last
  // register is the output register; hold it until out_ready.
  pdmd_drv u_drv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (m_valid),
    .up_ready (m_ready),
    .prod_p   (m_prod_p),
    .prod_i   (m_prod_i),
    .prod_d   (m_prod_d),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .left     (left),
    .right    (right)
  );

  assign out_left_forward  = left.fwd;
  assign out_left_pulse    = left.pulse;
  assign out_right_forward = right.fwd;
  assign out_right_pulse   = right.pulse;

endmodule

`default_nettype wire

### test/pid_differential_motor_drive_tb.sv
// Self-checking bench for pid_differential_motor_drive: drives position samples and
// register writes, predicts both drive outputs and checks every result transaction.
// Depends on pdmd_pkg (design/pdmd_pkg.sv) and the pid_differential_motor_drive RTL.
module pid_differential_motor_drive_tb;
  import pdmd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PIPE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int GAIN_MAX = (1 << (GAIN_BITS - 1)) - 1;
  localparam int GAIN_MIN = -(1 << (GAIN_BITS - 1));
  localparam int PULSE_TOP = 1000000;
  localparam int LIMIT_MAX = (1 << LIMIT_BITS) - 1;
  // Index just past the register map; writes there must leave everything alone.
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    drive_out_t left;
    drive_out_t right;
  } drive_pair_t;

  // Holds its own copy of the configuration and of the error history, turns every
  // accepted sample into the expected pair of drives and compares results in order.
  class drive_scoreboard;
    sample_t setpoint;
    gain_t prop_gain;
    gain_t integ_gain;
    gain_t deriv_gain;
    pulse_t base_speed;
    limit_t integ_lim;
    pulse_t pulse_lim;
    err_t last_err;
    sum_t err_total;
    drive_pair_t expected_drives[$];
    int unsigned failures;

    function new();
      setpoint = RST_SETPOINT;
      prop_gain = RST_PROP_GAIN;
      integ_gain = RST_INTEG_GAIN;
      deriv_gain = RST_DERIV_GAIN;
      base_speed = RST_BASE_SPEED;
      integ_lim = RST_INTEG_LIM;
      pulse_lim = RST_PULSE_LIM;
      last_err = '0;
      err_total = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_SETPOINT:   setpoint = data[SAMPLE_BITS-1:0];
        REG_PROP_GAIN:  prop_gain = data[GAIN_BITS-1:0];
        REG_INTEG_GAIN: integ_gain = data[GAIN_BITS-1:0];
        REG_DERIV_GAIN: deriv_gain = data[GAIN_BITS-1:0];
        REG_BASE_SPEED: base_speed = data[DRIVE_BITS-1:0];
        REG_INTEG_LIM:  integ_lim = data[LIMIT_BITS-1:0];
        REG_PULSE_LIM:  pulse_lim = data[DRIVE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Direction from the sign, magnitude clipped at the pulse limit.
    function drive_out_t drive_of(longint level);
      drive_out_t d;
      longint mag;
      mag = (level < 0) ? -level : level;
      if (mag > longint'(pulse_lim))
        mag = longint'(pulse_lim);
      d.fwd = (level >= 0);
      d.pulse = pulse_t'(mag);
      return d;
    endfunction

    function void note_position(sample_t pos);
      longint err, total, der, acc, corr, lim;
      drive_pair_t want;
      err = longint'(setpoint) - longint'(pos);
      total = longint'(err_total) + err;
      der = err - longint'(last_err);
      lim = longint'(integ_lim);
      if (total > lim)
        total = lim;
      else if (total < -lim)
        total = -lim;
      err_total = sum_t'(total);
      last_err = err_t'(err);
      acc = longint'(prop_gain) * err + longint'(integ_gain) * total
          + longint'(deriv_gain) * der;
      corr = acc >>> FRAC_BITS;
      want.left = drive_of(longint'(base_speed) - corr);
      want.right = drive_of(longint'(base_speed) + corr);
      expected_drives.push_back(want);
    endfunction

    function void check_drive(drive_pair_t got);
      drive_pair_t want;
      if (expected_drives.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected drive result: left %0b/%0d right %0b/%0d",
                   got.left.fwd, got.left.pulse, got.right.fwd, got.right.pulse);
        return;
      end
      want = expected_drives.pop_front();
      if (got.left.fwd !== want.left.fwd || got.left.pulse !== want.left.pulse ||
          got.right.fwd !== want.right.fwd || got.right.pulse !== want.right.pulse) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("drive mismatch: left fwd exp %0b got %0b, pulse exp %0d got %0d; %s",
                   want.left.fwd, got.left.fwd, want.left.pulse, got.left.pulse,
                   $sformatf("right fwd exp %0b got %0b, pulse exp %0d got %0d",
                             want.right.fwd, got.right.fwd,
                             want.right.pulse, got.right.pulse));
      end
    endfunction

    function void check_drained();
      if (expected_drives.size() != 0) begin
        failures += expected_drives.size();
        $display("%0d expected drive results never arrived", expected_drives.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_left_forward;
  pulse_t out_left_pulse;
  logic out_right_forward;
  pulse_t out_right_pulse;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Idle knobs, percent of cycles; hold_active forces a long receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic hold_active = 1'b0;

  drive_scoreboard drive_sb = new();

  pid_differential_motor_drive DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_forward (out_left_forward),
    .out_left_pulse   (out_left_pulse),
    .out_right_forward(out_right_forward),
    .out_right_pulse  (out_right_pulse),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: sample the handshake right after the edge (pre-edge values),
  // check any transaction that completed, then pick the next ready level.
  always @(posedge clk) begin
    drive_pair_t got;
    if (rst_n && out_valid && out_ready) begin
      got.left.fwd = out_left_forward;
      got.left.pulse = out_left_pulse;
      got.right.fwd = out_right_forward;
      got.right.pulse = out_right_pulse;
      drive_sb.check_drive(got);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run as failed if the stimulus never completes.
  initial begin
    int unsigned cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
      @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Offer one sample after a random run of idle cycles, drawn one cycle at a time,
  // and hold it until accepted.
  // Leave valid high on return so back-to-back transactions need no extra edge.
  task automatic send_position(input sample_t pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    drive_sb.note_position(pos);
  endtask

  // Write one register through the APB port. Fill the bits above the register's
  // width with junk so the masking gets exercised on every write.
  task automatic load_reg(input logic [2:0] idx, input int value);
    int unsigned width;
    logic [31:0] keep, data;
    case (idx)
      REG_SETPOINT: width = SAMPLE_BITS;
      REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN: width = GAIN_BITS;
      REG_BASE_SPEED, REG_PULSE_LIM: width = DRIVE_BITS;
      REG_INTEG_LIM: width = LIMIT_BITS;
      default: width = 0;
    endcase
    keep = (32'd1 << width) - 32'd1;
    data = ($urandom() & ~keep) | (value & keep);
    // setup phase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    // access phase; the register takes the value on the edge with pready high
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    drive_sb.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int sp, input int kp, input int ki, input int kd,
                                input int base, input int ilim, input int plim);
    load_reg(REG_SETPOINT, sp);
    load_reg(REG_PROP_GAIN, kp);
    load_reg(REG_INTEG_GAIN, ki);
    load_reg(REG_DERIV_GAIN, kd);
    load_reg(REG_BASE_SPEED, base);
    load_reg(REG_INTEG_LIM, ilim);
    load_reg(REG_PULSE_LIM, plim);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_sb.expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Stall the result side for a long stretch while the sender keeps pushing.
  task automatic hold_off(input int unsigned cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  // Gains spread over many magnitudes so that some runs saturate and some don't.
  function automatic int rand_gain();
    int unsigned k, mag;
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
    k = $urandom_range(4, GAIN_BITS - 1);
    mag = $urandom_range(0, (1 << k) - 1);
    return $urandom_range(1) ? -int'(mag) - 1 : int'(mag);
  endfunction

  function automatic int rand_drive_level();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? PULSE_TOP : 0;
    return $urandom_range(PULSE_TOP);
  endfunction

  task automatic randomize_settings();
    int sp, ilim;
    sp = ($urandom_range(3) == 0) ? ($urandom_range(1) ? SAMPLE_MAX : 0)
                                  : $urandom_range(SAMPLE_MAX);
    if ($urandom_range(3) == 0)
      ilim = $urandom_range(1) ? LIMIT_MAX : 0;
    else
      ilim = $urandom_range($urandom_range(1) ? 255 : LIMIT_MAX);
    apply_settings(sp, rand_gain(), rand_gain(), rand_gain(), rand_drive_level(), ilim,
                   rand_drive_level());
  endtask

  // Mostly uniform samples, with extra weight on the rails and on the setpoint.
  function automatic sample_t pick_position();
    int unsigned roll;
    int near;
    roll = $urandom_range(99);
    if (roll < 15)
      return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(0);
    if (roll < 30) begin
      near = int'(drive_sb.setpoint) + int'($urandom_range(16)) - 8;
      if (near < 0)
        near = 0;
      if (near > SAMPLE_MAX)
        near = SAMPLE_MAX;
      return sample_t'(near);
    end
    return sample_t'($urandom_range(SAMPLE_MAX));
  endfunction

  initial begin
    int unsigned seg, n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings. The first sample sees a zero previous error; the run of
    // full-scale samples drives the integral negative, short of its clamp.
    send_position(162);
    send_position(0);
    send_position(SAMPLE_MAX);
    send_position(SAMPLE_MAX);
    send_position(SAMPLE_MAX);
    settle();

    // Unit gains, small limits: clamp, saturation and reverse drive all show up.
    // Also hit the address past the map, which must change nothing.
    apply_settings(0, 256, 256, -256, 500, 100, 700);
    load_reg(REG_UNMAPPED, $urandom());
    send_position(0);
    send_position(SAMPLE_MAX);
    send_position(SAMPLE_MAX);
    send_position(0);
    send_position(512);
    settle();

    // Zero integral limit keeps the sum at zero; zero pulse limit zeroes both pulses.
    apply_settings(300, 256, 512, 128, 400, 0, 0);
    send_position(SAMPLE_MAX);
    send_position(0);
    send_position(300);
    settle();

    // All gains and base at zero: the drive is exactly zero and counts as forward.
    apply_settings(700, 0, 0, 0, 0, LIMIT_MAX, PULSE_TOP);
    send_position(5);
    send_position(1000);
    settle();

    // Extreme gains at the widest limits.
    apply_settings(SAMPLE_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, PULSE_TOP, LIMIT_MAX, PULSE_TOP);
    send_position(0);
    send_position(0);
    send_position(SAMPLE_MAX);
    settle();

    // Random part: two segments per idling mode, new settings for each segment.
    for (seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 51;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      randomize_settings();
      for (n = 0; n < 62; n++) begin
        // Fill the pipe against a blocked receiver once, with the sender at full rate.
        if (seg == 0 && n == 20)
          fork
            hold_off(80);
          join_none
        send_position(pick_position());
      end
      settle();
    end

    drive_sb.check_drained();
    if (drive_sb.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
